// ===== rtl/muscle_force_velocity_power_macros.svh =====
// ----------------------------------------------------------------------------
// muscle force-velocity power: assertion macros
// concurrent checks clocked on aclk, held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef MUSCLE_FORCE_VELOCITY_POWER_MACROS_SVH
`define MUSCLE_FORCE_VELOCITY_POWER_MACROS_SVH

// same-cycle implication
`define MFVP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFVP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mfvp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfvp_pkg
// fixed-point constants and register indexes of the force-velocity block
// ----------------------------------------------------------------------------
package mfvp_pkg;

    typedef enum logic [1:0] {
        REG_MAX_VELOCITY    = 2'd0,
        REG_ISOMETRIC_FORCE = 2'd1,
        REG_CURVE_SHAPE     = 2'd2
    } reg_idx_t;

    localparam logic [30:0] MAX_VELOCITY_RST    = 31'd65536;
    localparam logic [30:0] ISOMETRIC_FORCE_RST = 31'd0;
    localparam logic [30:0] CURVE_SHAPE_RST     = 31'd65536;

    localparam logic [14:0] ACT_ONE   = 15'd16384;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    localparam logic [18:0] C_756_Q16 = 19'd495452;
    localparam logic [30:0] C_18      = 31'd1932735283;
    localparam logic [29:0] C_08      = 30'd858993459;
    localparam logic [25:0] C_054     = 26'd57982058;
    localparam logic [29:0] C_506     = 30'd543313363;
    localparam logic [31:0] C_246     = 32'd2641404887;
    localparam logic [30:0] C_113     = 31'd1213328261;
    localparam logic [30:0] C_164     = 31'd1760936591;

endpackage

// ===== rtl/muscle_force_velocity_power.sv =====
// ----------------------------------------------------------------------------
// muscle_force_velocity_power
// force-velocity tension and metabolic power of one muscle per word
// ----------------------------------------------------------------------------
// usage
//   s_ words carry activation (Q2.14) and strap velocity (Q16.16); m_ words
//   carry tension (Q16.16), metabolic power (Q32.16) and a saturation flag
//   registers (vmax, F0, K) are written over the APB port; the user must write
//   them only while idle, as the block itself does not enforce it
// throughput
//   one word is taken every cycle unless stalled; four bit-per-stage dividers in
//   series set the depth (curvature term, force ratio, relative velocity, sigma)
// reset
//   aresetn clears every valid bit and loads the register defaults
// stall
//   the whole pipeline holds while a result waits with m_tready low;
//   s_tready then falls, nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "muscle_force_velocity_power_macros.svh"

module muscle_force_velocity_power
    import mfvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // activation[15:0], strap_velocity[47:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // tension[31:0], metabolic_power[79:32]
    output logic [0:0]  m_tuser,   // saturated[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0] vmax_reg, f0_reg, k_reg;
    logic [30:0] vmax_eff, k_eff;
    logic        en;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vmax_reg <= MAX_VELOCITY_RST;
            f0_reg   <= ISOMETRIC_FORCE_RST;
            k_reg    <= CURVE_SHAPE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_MAX_VELOCITY:    vmax_reg <= pwdata[30:0];
                REG_ISOMETRIC_FORCE: f0_reg   <= pwdata[30:0];
                REG_CURVE_SHAPE:     k_reg    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_MAX_VELOCITY:    prdata = {1'b0, vmax_reg};
            REG_ISOMETRIC_FORCE: prdata = {1'b0, f0_reg};
            REG_CURVE_SHAPE:     prdata = {1'b0, k_reg};
            default:             prdata = '0;
        endcase
    end

    assign vmax_eff = (vmax_reg == '0) ? 31'd1 : vmax_reg;
    assign k_eff    = (k_reg == '0) ? 31'd1 : k_reg;

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    // stage 1: clamp activation and velocity
    logic signed [15:0] act;
    logic signed [31:0] sv;
    logic [31:0] sv_mag;
    logic [14:0] s1_a_next;
    logic [30:0] s1_mv_next;
    logic        s1_neg_next;
    logic        s1_vld_reg, s1_neg_reg;
    logic [14:0] s1_a_reg;
    logic [30:0] s1_mv_reg;

    assign act         = s_tdata[15:0];
    assign sv          = s_tdata[47:16];
    assign sv_mag      = sv[31] ? 32'(~sv + 32'sd1) : 32'(sv);
    assign s1_neg_next = !sv[31] && (sv != 32'sd0);
    assign s1_mv_next  = (sv_mag > {1'b0, vmax_eff}) ? vmax_eff : sv_mag[30:0];
    assign s1_a_next   = act[15] ? 15'd0 :
                         (act > 16'sd16384) ? ACT_ONE : act[14:0];

    // stage 2: curvature numerator and activated force
    logic        s2_vld_reg, s2_neg_reg;
    logic [14:0] s2_a_reg;
    logic [30:0] s2_mv_reg, s2_af_reg;
    logic [49:0] s2_num_reg;

    // stage 3: curve denominator, force-ratio numerator, power scale
    logic        s3_vld_reg, s3_neg_reg;
    logic [14:0] s3_a_reg;
    logic [30:0] s3_mv_reg, s3_diff_reg;
    logic [50:0] s3_d_reg;
    logic [45:0] s3_p_reg;

    logic        d1_vld;
    logic [49:0] d1_quo;
    logic [77:0] d1_side;
    logic [14:0] d1_a;
    logic [30:0] d1_mv, d1_af;
    logic        d1_neg;

    logic        d2_vld;
    logic [60:0] d2_quo;
    logic [92:0] d2_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= d1_vld;
        end
    end

    assign {d1_a, d1_mv, d1_neg, d1_af} = d1_side;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_a_reg    <= s1_a_next;
            s1_mv_reg   <= s1_mv_next;
            s1_neg_reg  <= s1_neg_next;
            s2_a_reg    <= s1_a_reg;
            s2_mv_reg   <= s1_mv_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_num_reg  <= s1_neg_reg ? 50'(50'(s1_mv_reg) * 50'(C_756_Q16))
                                      : {3'b0, s1_mv_reg, 16'b0};
            s2_af_reg   <= 31'((46'(f0_reg) * 46'(s1_a_reg)) >> 14);
            s3_a_reg    <= d1_a;
            s3_mv_reg   <= d1_mv;
            s3_neg_reg  <= d1_neg;
            s3_d_reg    <= 51'(vmax_eff) + 51'(d1_quo);
            s3_diff_reg <= vmax_eff - d1_mv;
            s3_p_reg    <= 46'((62'(vmax_eff) * 62'(d1_af)) >> 16);
        end
    end

    mfvp_div #(.NW(50), .DW(31), .SW(78)) u_div_curve (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s2_vld_reg),
        .in_num   (s2_num_reg),
        .in_den   (k_eff),
        .in_side  ({s2_a_reg, s2_mv_reg, s2_neg_reg, s2_af_reg}),
        .out_valid(d1_vld),
        .out_quo  (d1_quo),
        .out_side (d1_side)
    );

    mfvp_div #(.NW(61), .DW(51), .SW(93)) u_div_ratio (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s3_vld_reg),
        .in_num   ({s3_diff_reg, 30'b0}),
        .in_den   (s3_d_reg),
        .in_side  ({s3_a_reg, s3_mv_reg, s3_neg_reg, s3_p_reg}),
        .out_valid(d2_vld),
        .out_quo  (d2_quo),
        .out_side (d2_side)
    );

    // stages 4 to 7: lengthening branch, full force, tension
    logic [14:0] d2_a;
    logic [30:0] d2_mv;
    logic        d2_neg;
    logic [45:0] d2_p;

    logic        s4_vld_reg, s5_vld_reg, s6_vld_reg, s7_vld_reg;
    logic [14:0] s4_a_reg, s5_a_reg, s6_a_reg;
    logic [30:0] s4_mv_reg, s5_mv_reg, s6_mv_reg, s7_mv_reg;
    logic        s4_neg_reg, s5_neg_reg, s6_neg_reg, s7_neg_reg;
    logic [45:0] s4_p_reg, s5_p_reg, s6_p_reg, s7_p_reg;
    logic [30:0] s4_q_reg, s5_qf_reg;
    logic [60:0] s4_prod_reg;
    logic [31:0] s6_ffull_reg;
    logic [32:0] s7_tens_reg;

    assign {d2_a, d2_mv, d2_neg, d2_p} = d2_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= d2_vld;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_a_reg     <= d2_a;
            s4_mv_reg    <= d2_mv;
            s4_neg_reg   <= d2_neg;
            s4_p_reg     <= d2_p;
            s4_q_reg     <= d2_quo[30:0];
            s4_prod_reg  <= 61'(d2_quo[30:0]) * 61'(C_08);
            s5_a_reg     <= s4_a_reg;
            s5_mv_reg    <= s4_mv_reg;
            s5_neg_reg   <= s4_neg_reg;
            s5_p_reg     <= s4_p_reg;
            s5_qf_reg    <= s4_neg_reg ? 31'(C_18 - 31'(s4_prod_reg >> 30)) : s4_q_reg;
            s6_a_reg     <= s5_a_reg;
            s6_mv_reg    <= s5_mv_reg;
            s6_neg_reg   <= s5_neg_reg;
            s6_p_reg     <= s5_p_reg;
            s6_ffull_reg <= 32'((62'(f0_reg) * 62'(s5_qf_reg)) >> 30);
            s7_mv_reg    <= s6_mv_reg;
            s7_neg_reg   <= s6_neg_reg;
            s7_p_reg     <= s6_p_reg;
            s7_tens_reg  <= 33'((47'(s6_ffull_reg) * 47'(s6_a_reg)) >> 14);
        end
    end

    logic [31:0] tension_sat;
    logic        tsat;
    assign tsat        = s7_tens_reg[32];
    assign tension_sat = tsat ? '1 : s7_tens_reg[31:0];

    logic        d3_vld;
    logic [60:0] d3_quo;
    logic [79:0] d3_side;
    logic        d3_neg, d3_tsat;
    logic [31:0] d3_tension;
    logic [45:0] d3_p;

    mfvp_div #(.NW(61), .DW(31), .SW(80)) u_div_rel (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s7_vld_reg),
        .in_num   ({s7_mv_reg, 30'b0}),
        .in_den   (vmax_eff),
        .in_side  ({s7_neg_reg, tension_sat, tsat, s7_p_reg}),
        .out_valid(d3_vld),
        .out_quo  (d3_quo),
        .out_side (d3_side)
    );

    assign {d3_neg, d3_tension, d3_tsat, d3_p} = d3_side;

    // stages 8 to 11: sigma polynomial terms
    logic        s8_vld_reg, s9_vld_reg, s10_vld_reg, s11_vld_reg;
    logic        s8_neg_reg, s9_neg_reg, s10_neg_reg;
    logic [31:0] s8_ten_reg, s9_ten_reg, s10_ten_reg, s11_ten_reg;
    logic        s8_ts_reg, s9_ts_reg, s10_ts_reg, s11_ts_reg;
    logic [45:0] s8_p_reg, s9_p_reg, s10_p_reg, s11_p_reg;
    logic [30:0] s8_m1_reg, s8_p2_reg, s8_t506_reg, s8_t113_reg;
    logic [30:0] s9_p2_reg, s9_p3_reg, s9_t506_reg, s9_t113_reg, s9_t08_reg;
    logic [31:0] s9_t246_reg, s10_t246_reg;
    logic [30:0] s10_p2_reg, s10_t506_reg, s10_t113_reg, s10_t08_reg, s10_t164_reg;
    logic [31:0] s11_num_reg;
    logic [34:0] s11_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
        end else if (en) begin
            s8_vld_reg  <= d3_vld;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
        end
    end

    logic signed [36:0] t506_s, t113_s, t164_s, num_s, den_s;
    logic [31:0] num_next;
    logic [34:0] den_next;

    assign t506_s = s10_neg_reg ? -$signed(37'(s10_t506_reg)) : $signed(37'(s10_t506_reg));
    assign t113_s = s10_neg_reg ? -$signed(37'(s10_t113_reg)) : $signed(37'(s10_t113_reg));
    assign t164_s = s10_neg_reg ? -$signed(37'(s10_t164_reg)) : $signed(37'(s10_t164_reg));
    assign num_s  = $signed(37'(C_054)) + t506_s + $signed(37'(s10_t246_reg));
    assign den_s  = $signed(37'(ONE_Q30)) - t113_s
                  + $signed(37'(37'(s10_p2_reg) * 37'd12))
                  + $signed(37'(s10_t08_reg)) - t164_s;
    assign num_next = num_s[36] ? 32'd0 : num_s[31:0];
    assign den_next = (den_s < 37'sd1) ? 35'd1 : den_s[34:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            s8_neg_reg   <= d3_neg;
            s8_ten_reg   <= d3_tension;
            s8_ts_reg    <= d3_tsat;
            s8_p_reg     <= d3_p;
            s8_m1_reg    <= d3_quo[30:0];
            s8_p2_reg    <= 31'((62'(d3_quo[30:0]) * 62'(d3_quo[30:0])) >> 30);
            s8_t506_reg  <= 31'((61'(d3_quo[30:0]) * 61'(C_506)) >> 30);
            s8_t113_reg  <= 31'((62'(d3_quo[30:0]) * 62'(C_113)) >> 30);

            s9_neg_reg   <= s8_neg_reg;
            s9_ten_reg   <= s8_ten_reg;
            s9_ts_reg    <= s8_ts_reg;
            s9_p_reg     <= s8_p_reg;
            s9_p2_reg    <= s8_p2_reg;
            s9_t506_reg  <= s8_t506_reg;
            s9_t113_reg  <= s8_t113_reg;
            s9_p3_reg    <= 31'((62'(s8_p2_reg) * 62'(s8_m1_reg)) >> 30);
            s9_t246_reg  <= 32'((63'(s8_p2_reg) * 63'(C_246)) >> 30);
            s9_t08_reg   <= 31'((61'(s8_p2_reg) * 61'(C_08)) >> 30);

            s10_neg_reg  <= s9_neg_reg;
            s10_ten_reg  <= s9_ten_reg;
            s10_ts_reg   <= s9_ts_reg;
            s10_p_reg    <= s9_p_reg;
            s10_p2_reg   <= s9_p2_reg;
            s10_t506_reg <= s9_t506_reg;
            s10_t113_reg <= s9_t113_reg;
            s10_t246_reg <= s9_t246_reg;
            s10_t08_reg  <= s9_t08_reg;
            s10_t164_reg <= 31'((62'(s9_p3_reg) * 62'(C_164)) >> 30);

            s11_ten_reg  <= s10_ten_reg;
            s11_ts_reg   <= s10_ts_reg;
            s11_p_reg    <= s10_p_reg;
            s11_num_reg  <= num_next;
            s11_den_reg  <= den_next;
        end
    end

    logic        d4_vld;
    logic [61:0] d4_quo;
    logic [78:0] d4_side;
    logic [31:0] d4_tension;
    logic        d4_tsat;
    logic [45:0] d4_p;

    mfvp_div #(.NW(62), .DW(35), .SW(79)) u_div_sigma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s11_vld_reg),
        .in_num   ({s11_num_reg, 30'b0}),
        .in_den   (s11_den_reg),
        .in_side  ({s11_ten_reg, s11_ts_reg, s11_p_reg}),
        .out_valid(d4_vld),
        .out_quo  (d4_quo),
        .out_side (d4_side)
    );

    assign {d4_tension, d4_tsat, d4_p} = d4_side;

    // stages 12 to 14: sigma cap, split power product, output word
    logic        s12_vld_reg, s13_vld_reg, m_vld_reg;
    logic [31:0] s12_ten_reg, s13_ten_reg, s12_sigma_reg;
    logic        s12_ts_reg, s13_ts_reg;
    logic [45:0] s12_p_reg;
    logic [54:0] s13_x_reg, s13_y_reg;
    logic [79:0] m_data_reg;
    logic        m_user_reg;
    logic [47:0] power_next;

    assign power_next = 48'(({s13_x_reg, 23'b0} + 78'(s13_y_reg)) >> 30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else if (en) begin
            s12_vld_reg <= d4_vld;
            s13_vld_reg <= s12_vld_reg;
            m_vld_reg   <= s13_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s12_ten_reg   <= d4_tension;
            s12_ts_reg    <= d4_tsat;
            s12_p_reg     <= d4_p;
            s12_sigma_reg <= (d4_quo[61:32] != '0) ? '1 : d4_quo[31:0];
            s13_ten_reg   <= s12_ten_reg;
            s13_ts_reg    <= s12_ts_reg;
            s13_x_reg     <= 55'(s12_p_reg[45:23]) * 55'(s12_sigma_reg);
            s13_y_reg     <= 55'(s12_p_reg[22:0]) * 55'(s12_sigma_reg);
            m_data_reg    <= {power_next, s13_ten_reg};
            m_user_reg    <= s13_ts_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `MFVP_ASSERT_IMP(a_ratio_range, d2_vld, d2_quo <= 61'(ONE_Q30), "force ratio above one")
    `MFVP_ASSERT_IMP(a_rel_range, d3_vld, d3_quo <= 61'(ONE_Q30), "relative velocity above one")
    `MFVP_ASSERT_IMP(a_no_tension_sat, m_tvalid, !m_tuser[0], "tension clipped")
    `MFVP_ASSERT_NXT(a_stall_hold, !en, $stable(s1_mv_reg) && $stable(s7_tens_reg),
                     "pipeline moved while stalled")

endmodule

// ===== rtl/mfvp_div.sv =====
// ----------------------------------------------------------------------------
// mfvp_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module mfvp_div #(
    parameter int NW = 50,
    parameter int DW = 31,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] dq_reg   [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];
    logic          val_reg  [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW-1:0] rem_cur;
        logic [NW-1:0] dq_cur;
        logic [DW-1:0] den_cur;
        logic [SW-1:0] side_cur;
        logic          val_cur;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] dq_next;

        if (i == 0) begin : g_first
            assign rem_cur  = '0;
            assign dq_cur   = in_num;
            assign den_cur  = in_den;
            assign side_cur = in_side;
            assign val_cur  = in_valid;
        end else begin : g_rest
            assign rem_cur  = rem_reg[i-1];
            assign dq_cur   = dq_reg[i-1];
            assign den_cur  = den_reg[i-1];
            assign side_cur = side_reg[i-1];
            assign val_cur  = val_reg[i-1];
        end

        assign trial    = {rem_cur, dq_cur[NW-1]};
        assign ge       = (trial >= {1'b0, den_cur});
        assign rem_next = ge ? DW'(trial - {1'b0, den_cur}) : trial[DW-1:0];
        assign dq_next  = {dq_cur[NW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[i] <= 1'b0;
            end else if (en) begin
                val_reg[i] <= val_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                dq_reg[i]   <= dq_next;
                den_reg[i]  <= den_cur;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = val_reg[NW-1];
    assign out_quo   = dq_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule
